// File: sv/hfr_pkg.sv
// Shared types and constants for the HART frame receiver.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package hfr_pkg;

    // Input item: one received byte or a control request
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  rx_byte;
        logic        line_error;
        logic [31:0] arrival_time;
        logic        transmit_active;
    } t_in_item;

    // Result item: one per input item
    typedef struct packed {
        logic        store_valid;
        logic [8:0]  store_index;
        logic [7:0]  store_byte;
        logic        frame_done;
        logic        receive_error;
        logic        check_error;
    } t_out_item;

    // Item modes
    localparam logic [1:0] MODE_BYTE    = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_CARRIER = 2'd2;

    // Framing constants
    localparam logic [7:0]  PREAMBLE_BYTE  = 8'hFF;
    localparam logic [31:0] GAP_LIMIT_RST  = 32'd636;

    // Delimiter frame types (bits 2..0)
    localparam logic [2:0] FT_BACK = 3'd1;
    localparam logic [2:0] FT_STX  = 3'd2;
    localparam logic [2:0] FT_ACK  = 3'd6;

    // Buffer positions where header fields end
    localparam logic [8:0] ADDR_END_LONG   = 9'd6;
    localparam logic [8:0] ADDR_END_SHORT  = 9'd2;
    localparam logic [8:0] DATA_BASE_LONG  = 9'd9;
    localparam logic [8:0] DATA_BASE_SHORT = 9'd5;

endpackage

// File: sv/hfr_in_stage.sv
// Input register of the HART frame receiver: holds one item for the parser.
// Depends on hfr_pkg for the input item type.
`timescale 1ns / 1ps

module hfr_in_stage
    import hfr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    input  logic     i_pop,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    // Take a new item when empty or when the held one leaves this cycle
    assign o_in_ready = !r_valid || i_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: sv/hfr_parser.sv
// Frame parser of the HART frame receiver: parse state, gap limit register
// and the per-item next-state logic. Depends on hfr_pkg.
`timescale 1ns / 1ps

module hfr_parser
    import hfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_step,
    input  t_in_item    i_item,
    output t_out_item   o_result
);

    typedef enum logic [8:0] {
        PH_WAIT  = 9'b000000001,
        PH_PRE   = 9'b000000010,
        PH_DELIM = 9'b000000100,
        PH_LADDR = 9'b000001000,
        PH_SADDR = 9'b000010000,
        PH_EXP   = 9'b000100000,
        PH_CMD   = 9'b001000000,
        PH_COUNT = 9'b010000000,
        PH_DATA  = 9'b100000000
    } t_phase;

    t_phase      r_phase,    n_phase;
    logic [8:0]  r_pos,      n_pos;
    logic [8:0]  r_fend,     n_fend;
    logic [7:0]  r_xor,      n_xor;
    logic [7:0]  r_delim,    n_delim;
    logic [31:0] r_last,     n_last;
    logic [1:0]  r_flags,    n_flags;
    logic        r_pending,  n_pending;
    logic [31:0] r_gap_limit;

    t_phase      cur_phase;
    logic [31:0] gap;
    logic [7:0]  b;
    logic [1:0]  exp_cnt;
    logic [8:0]  addr_end;
    logic [8:0]  data_base;
    logic [8:0]  pos_inc;
    logic [7:0]  xor_inc;
    logic        type_ok;
    logic        data_path;
    logic [1:0]  flags_tmp;

    assign b         = i_item.rx_byte;
    assign exp_cnt   = r_delim[6:5];
    assign addr_end  = r_delim[7] ? ADDR_END_LONG : ADDR_END_SHORT;
    assign data_base = r_delim[7] ? DATA_BASE_LONG : DATA_BASE_SHORT;
    assign pos_inc   = r_pos + 9'd1;
    assign xor_inc   = r_xor ^ b;
    assign type_ok   = b[2:0] inside {FT_BACK, FT_STX, FT_ACK};
    assign gap       = i_item.arrival_time - r_last;

    // Next state and result for the item in the input register
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_fend    = r_fend;
        n_xor     = r_xor;
        n_delim   = r_delim;
        n_last    = r_last;
        n_flags   = r_flags;
        n_pending = r_pending;
        o_result  = '0;
        cur_phase = r_phase;
        data_path = 1'b0;
        flags_tmp = r_flags;
        if (i_step) begin
            case (i_item.mode)
                MODE_RELEASE: begin
                    n_pending = 1'b0;
                end
                MODE_CARRIER: begin
                    if (!r_pending) begin
                        n_phase = PH_WAIT;
                    end
                end
                MODE_BYTE: begin
                    if (!i_item.transmit_active && !r_pending) begin
                        // Restart the hunt after a long gap
                        if (gap > r_gap_limit) begin
                            cur_phase = PH_WAIT;
                        end
                        n_phase = cur_phase;
                        n_last  = i_item.arrival_time;
                        case (cur_phase)
                            PH_WAIT: begin
                                if (b == PREAMBLE_BYTE) begin
                                    n_phase = PH_PRE;
                                end
                            end
                            PH_PRE: begin
                                n_phase = (b == PREAMBLE_BYTE) ? PH_DELIM : PH_WAIT;
                            end
                            PH_DELIM: begin
                                if (b != PREAMBLE_BYTE) begin
                                    if (!type_ok) begin
                                        n_phase = PH_WAIT;
                                    end else begin
                                        n_delim = b;
                                        n_xor   = b;
                                        o_result.store_valid = 1'b1;
                                        o_result.store_byte  = b;
                                        n_pos   = 9'd1;
                                        if (b[7]) begin
                                            n_phase = PH_LADDR;
                                            n_fend  = ADDR_END_LONG;
                                        end else begin
                                            n_phase = PH_SADDR;
                                        end
                                    end
                                end
                            end
                            default: begin
                                // Store the byte and fold it into the check
                                o_result.store_valid = 1'b1;
                                o_result.store_index = r_pos;
                                o_result.store_byte  = b;
                                n_pos = pos_inc;
                                n_xor = xor_inc;
                                case (cur_phase)
                                    PH_LADDR, PH_SADDR: begin
                                        if (cur_phase == PH_SADDR || pos_inc == r_fend) begin
                                            if (exp_cnt != 2'd0) begin
                                                n_phase = PH_EXP;
                                                n_fend  = addr_end + {7'd0, exp_cnt};
                                            end else begin
                                                n_phase = PH_CMD;
                                            end
                                        end
                                    end
                                    PH_EXP: begin
                                        if (pos_inc == r_fend) begin
                                            n_phase = PH_CMD;
                                        end
                                    end
                                    PH_COUNT: begin
                                        n_phase = PH_DATA;
                                        n_fend  = data_base + {7'd0, exp_cnt} + {1'b0, b};
                                    end
                                    PH_CMD: begin
                                        flags_tmp = 2'b00;
                                        n_phase   = PH_COUNT;
                                        data_path = 1'b1;
                                    end
                                    default: begin
                                        data_path = 1'b1;
                                    end
                                endcase
                            end
                        endcase

                        if (data_path) begin
                            flags_tmp[0] = flags_tmp[0] | i_item.line_error;
                            // Last byte of the frame: report and hold
                            if (cur_phase == PH_DATA && pos_inc == r_fend) begin
                                flags_tmp[1] = flags_tmp[1] | (xor_inc != 8'd0);
                                o_result.frame_done    = 1'b1;
                                o_result.receive_error = flags_tmp[0];
                                o_result.check_error   = flags_tmp[1];
                                n_pending = 1'b1;
                                n_phase   = PH_WAIT;
                            end
                            n_flags = flags_tmp;
                        end else if (i_item.line_error) begin
                            n_phase = PH_WAIT;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_WAIT;
            r_pos     <= '0;
            r_fend    <= '0;
            r_xor     <= '0;
            r_delim   <= '0;
            r_last    <= '0;
            r_flags   <= '0;
            r_pending <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_fend    <= n_fend;
            r_xor     <= n_xor;
            r_delim   <= n_delim;
            r_last    <= n_last;
            r_flags   <= n_flags;
            r_pending <= n_pending;
        end
    end

    // Gap limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_limit <= GAP_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_gap_limit <= i_cfg_wdata;
        end
    end

endmodule

// File: sv/hfr_out_stage.sv
// Result register of the HART frame receiver, decoupling the parser from
// the downstream handshake. Depends on hfr_pkg for the result item type.
`timescale 1ns / 1ps

module hfr_out_stage
    import hfr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_item,
    output logic      o_free,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      r_valid;
    t_out_item r_item;

    // Slot opens when empty or when the held item is taken this cycle
    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_item <= i_item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

// File: sv/hart_frame_receiver_top.sv
// Top level of the HART frame receiver: input register, parser, result register.
// Depends on hfr_pkg, hfr_in_stage, hfr_parser and hfr_out_stage.
`timescale 1ns / 1ps
//
// Usage
//   Input channel (i_in_valid / o_in_ready / i_in_item): one item per UART byte
//   or control request (release pending frame, carrier on). Output channel
//   (o_out_valid / i_out_ready / o_out_item): exactly one result item per
//   input item, in order, carrying the store strobe, buffer index and byte,
//   and the frame-done and error flags.
//   Configuration: i_cfg_we / i_cfg_wdata write the inter-byte gap limit in
//   ticks; write it only while no item is in flight.
//   Path: an accepted item is loaded into the input register, and its result
//   then into the result register, which offers it.
//   Throughput: one item per cycle while i_out_ready is high; the parse state
//   updates once per item in the parser, so items follow each other back to back.
//   Reset: synchronous, active low; clears both stages, the parse state
//   (hunting for preamble, no frame pending) and sets the gap limit to 636.
//   Stall: when i_out_ready is low the result register holds its item; the
//   input register still takes one more item, then o_in_ready drops until
//   the result moves on.

module hart_frame_receiver_top
    import hfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    logic      held_valid;
    t_in_item  held_item;
    logic      out_free;
    logic      step;
    t_out_item result;

    // Advance an item when one is held and the result slot is open
    assign step = held_valid && out_free;

    hfr_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_pop      (step),
        .o_valid    (held_valid),
        .o_item     (held_item)
    );

    hfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (step),
        .i_item      (held_item),
        .o_result    (result)
    );

    hfr_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (step),
        .i_item      (result),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
